// File: rtl/core/lcfp_pkg.sv
// Package for the length/checksum frame parser.
// Holds sizes, reset values and the controller/datapath interface structs.
// No dependencies.
package lcfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int BUFFER_SIZE = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TDATA_W     = 32;
    localparam int TDATA_USED  = 2 * BYTE_W + 2 * ADDR_W;

    localparam logic [BYTE_W-1:0] START_RESET = 8'h61;

    // controller -> datapath
    typedef struct packed {
        logic seed;      // start byte seen: seed checksum, clear count
        logic take_len;  // latch length, add to checksum
        logic store;     // write payload byte, add to checksum
        logic rd_start;  // checksum matched: rewind read pointer
        logic rd_en;     // issue RAM read at read pointer
        logic rd_next;   // advance read pointer
    } lcfp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_start;
        logic len_ok;
        logic payload_done;
        logic sum_match;
    } lcfp_status_t;

endpackage

// File: rtl/core/lcfp_ram.sv
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module lcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: rtl/core/lcfp_ctrl.sv
// Frame parser controller: phase state machine and stream handshakes.
// Depends on lcfp_pkg.
module lcfp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  out_last,
    input  lcfp_pkg::lcfp_status_t status,
    output lcfp_pkg::lcfp_cmd_t    cmd
);
    import lcfp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_CHECK,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_LENGTH) ||
                       (state_reg == ST_PAYLOAD) || (state_reg == ST_CHECK);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && status.is_start)
                begin
                    cmd.seed   = 1'b1;
                    state_next = ST_LENGTH;
                end
            end
            ST_LENGTH:
            begin
                if (in_fire)
                begin
                    if (status.len_ok)
                    begin
                        cmd.take_len = 1'b1;
                        state_next   = ST_PAYLOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (in_fire)
                begin
                    cmd.store = 1'b1;
                    if (status.payload_done)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (in_fire)
                begin
                    if (status.sum_match)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/lcfp_datapath.sv
// Frame parser datapath: start byte register, checksum, counters and the
// payload store. Depends on lcfp_pkg and lcfp_ram.
module lcfp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lcfp_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic [lcfp_pkg::BYTE_W-1:0]   in_byte,
    input  lcfp_pkg::lcfp_cmd_t           cmd,
    output lcfp_pkg::lcfp_status_t        status,
    output logic [lcfp_pkg::BYTE_W-1:0]   message_id,
    output logic [lcfp_pkg::BYTE_W-1:0]   data_byte,
    output logic [lcfp_pkg::ADDR_W-1:0]   byte_index,
    output logic [lcfp_pkg::ADDR_W-1:0]   payload_length,
    output logic                          last
);
    import lcfp_pkg::*;

    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W-1:0] count_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [BYTE_W-1:0] msg_id_reg;
    logic [ADDR_W:0]   count_inc;
    logic [ADDR_W-1:0] ram_addr;

    assign sum_next  = sum_reg + in_byte;
    assign count_inc = {1'b0, count_reg} + 1'b1;

    assign status.is_start     = (in_byte == start_reg);
    assign status.len_ok       = ({1'b0, in_byte} < (BYTE_W+1)'(BUFFER_SIZE));
    assign status.payload_done = (count_inc >= {1'b0, len_reg});
    assign status.sum_match    = (in_byte == sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RESET;
            sum_reg    <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
            if (cmd.seed)
            begin
                sum_reg   <= in_byte;
                count_reg <= '0;
            end
            if (cmd.take_len)
            begin
                sum_reg <= sum_next;
                len_reg <= in_byte[ADDR_W-1:0];
            end
            if (cmd.store)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_inc[ADDR_W-1:0];
            end
            if (cmd.rd_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    // id byte kept beside the store so every result can carry it
    always_ff @(posedge clk)
    begin
        if (cmd.store && (count_reg == '0))
        begin
            msg_id_reg <= in_byte;
        end
    end

    assign ram_addr = cmd.store ? count_reg : rd_idx_reg;

    lcfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store),
        .re    (cmd.rd_en),
        .addr  (ram_addr),
        .wdata (in_byte),
        .rdata (data_byte)
    );

    assign message_id     = msg_id_reg;
    assign byte_index     = rd_idx_reg;
    assign payload_length = len_reg;
    assign last           = ({1'b0, rd_idx_reg} + 1'b1) == {1'b0, count_reg};

endmodule

// File: rtl/core/length_checksum_frame_parser_top.sv
// Start/length/payload deframer with 8-bit additive checksum.
// Input: one byte per cycle while receiving; the checksum byte is taken and,
// on a match, input then stalls while the stored payload is read out.
// Output: a matched frame of n stored bytes emits n results, each through a RAM
// read state and an output state held until taken; the first read follows the
// checksum byte. Reset (rst_n, async low) returns to idle, start byte = 0x61.
module length_checksum_frame_parser_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lcfp_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lcfp_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] in_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] message_id, [15:8] data_byte, [21:16] byte_index,
    // [27:22] payload_length, [31:28] zero
    output logic [lcfp_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast
);
    import lcfp_pkg::*;

    lcfp_cmd_t         cmd;
    lcfp_status_t      status;
    logic [BYTE_W-1:0] message_id;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_index;
    logic [ADDR_W-1:0] payload_length;
    logic              last;

    lcfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (last),
        .status    (status),
        .cmd       (cmd)
    );

    lcfp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_byte        (s_axis_tdata),
        .cmd            (cmd),
        .status         (status),
        .message_id     (message_id),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .payload_length (payload_length),
        .last           (last)
    );

    assign m_axis_tdata = {(TDATA_W-TDATA_USED)'(0), payload_length, byte_index,
                           data_byte, message_id};
    assign m_axis_tlast = last;

endmodule

// File: tb/sv/tb_length_checksum_frame_parser_top.sv
// Testbench for length_checksum_frame_parser_top: streams framed and junk bytes
// and checks every output request against a local parser model.
// Depends on lcfp_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_length_checksum_frame_parser_top;

    import lcfp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 12;
    localparam int RANDOM_BEATS = 48;

    // tdata bit positions of the output request
    localparam int DATA_LO = BYTE_W;
    localparam int IDX_LO  = 2 * BYTE_W;
    localparam int PLEN_LO = 2 * BYTE_W + ADDR_W;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_LENGTH,
        RX_PAYLOAD,
        RX_CHECK
    } rx_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] msg_id;
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] plen;
        logic              last;
    } frame_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [BYTE_W-1:0]   cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;

    // parser model state
    logic [BYTE_W-1:0]   rx_start = START_RESET;
    rx_phase_t           rx_phase = RX_IDLE;
    logic [ADDR_W-1:0]   rx_len = '0;
    logic [6:0]          rx_count = '0;
    logic [BYTE_W-1:0]   rx_sum = '0;
    logic [BYTE_W-1:0]   rx_store [STORE_DEPTH];

    frame_beat_t         pending_beats[$];
    logic [BYTE_W-1:0]   frame_start = START_RESET;
    int                  err_count = 0;
    int                  beats_checked = 0;
    int                  frame_bytes_sent = 0;
    int                  cycle_count = 0;
    bit                  steady = 1'b0;
    bit                  hold_req = 1'b0;

    length_checksum_frame_parser_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Advance the parser model by one accepted byte; a matching checksum
    // queues the whole run of stored bytes.
    function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
        frame_beat_t beat;
        int          n;
        case (rx_phase)
            RX_IDLE:
            begin
                if (b == rx_start)
                begin
                    rx_sum   = b;
                    rx_count = '0;
                    rx_phase = RX_LENGTH;
                end
            end
            RX_LENGTH:
            begin
                if (b < BUFFER_SIZE)
                begin
                    rx_len   = b[ADDR_W-1:0];
                    rx_sum   = rx_sum + b;
                    rx_phase = RX_PAYLOAD;
                end
                else
                    rx_phase = RX_IDLE;
            end
            RX_PAYLOAD:
            begin
                if (rx_count < STORE_DEPTH)
                    rx_store[rx_count[ADDR_W-1:0]] = b;
                rx_count = rx_count + 7'd1;
                rx_sum   = rx_sum + b;
                if (rx_count >= {1'b0, rx_len})
                    rx_phase = RX_CHECK;
            end
            default:
            begin
                rx_phase = RX_IDLE;
                if (b == rx_sum)
                begin
                    n = (rx_count > STORE_DEPTH) ? STORE_DEPTH : int'(rx_count);
                    for (int k = 0; k < n; k++)
                    begin
                        beat.msg_id = rx_store[0];
                        beat.data   = rx_store[k];
                        beat.idx    = ADDR_W'(k);
                        beat.plen   = rx_len;
                        beat.last   = (k == n - 1);
                        pending_beats.push_back(beat);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        frame_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected request: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("message_id", 32'(want.msg_id), 32'(m_axis_tdata[DATA_LO-1:0]));
                check_field("data_byte", 32'(want.data), 32'(m_axis_tdata[IDX_LO-1:DATA_LO]));
                check_field("byte_index", 32'(want.idx), 32'(m_axis_tdata[PLEN_LO-1:IDX_LO]));
                check_field("payload_length", 32'(want.plen),
                            32'(m_axis_tdata[TDATA_USED-1:PLEN_LO]));
                check_field("tdata_pad", 32'(0), 32'(m_axis_tdata[TDATA_W-1:TDATA_USED]));
                check_field("last", 32'(want.last), 32'(m_axis_tlast));
                beats_checked++;
            end
        end
    end

    // Output side: random short/long stalls, or one long hold on request.
    initial
    begin : ready_gen
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (stall_left == 0 && !steady && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // valid stays high across back-to-back requests; lowered only for a gap
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_rx_byte(b);
    endtask

    // fill < 0: random payload bytes, else every payload byte is fill
    task automatic send_frame(input logic [BYTE_W-1:0] len, input int fill,
                              input bit corrupt);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                count;
        sum = frame_start + len;
        send_byte(frame_start);
        send_byte(len);
        frame_bytes_sent += 2;
        if (len >= BUFFER_SIZE)
            return;
        count = (len == 0) ? 1 : int'(len);
        repeat (count)
        begin
            b   = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(corrupt ? (sum ^ BYTE_W'($urandom_range(1, 255))) : sum);
        frame_bytes_sent += count + 1;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [BYTE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        rx_start    = v;
        frame_start = v;
        cfg_we      <= 1'b0;
    endtask

    task automatic test_directed();
        // junk while idle
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_RESET ^ 8'h01);
        // zero length still carries one byte
        send_frame(8'd0, 8'h00, 1'b0);
        send_frame(8'd1, 8'hFF, 1'b0);
        send_frame(8'd2, -1, 1'b1);
        // oversize lengths, including the ones negative as signed
        send_frame(BYTE_W'(BUFFER_SIZE), -1, 1'b0);
        send_frame(8'd128, -1, 1'b0);
        send_frame(8'd255, -1, 1'b0);
        // start byte value inside the payload has no resync meaning
        send_frame(8'd3, START_RESET, 1'b0);
        drain_results();
    endtask

    task automatic test_start_byte_config();
        write_start_byte(8'h00);
        send_frame(8'd2, 8'h00, 1'b0);
        send_frame(8'd1, -1, 1'b1);
        drain_results();
        write_start_byte(8'hFF);
        send_frame(BYTE_W'(BUFFER_SIZE - 1), -1, 1'b0);
        drain_results();
        // start value usable as a length and as payload
        write_start_byte(8'h05);
        send_frame(8'd5, 8'h05, 1'b0);
        send_frame(8'd0, -1, 1'b0);
        drain_results();
        write_start_byte(BYTE_W'($urandom));
        send_frame(BYTE_W'($urandom_range(0, 7)), -1, 1'b0);
        drain_results();
        write_start_byte(START_RESET);
        drain_results();
    endtask

    task automatic test_random_frames();
        int               r;
        logic [BYTE_W-1:0] b;
        frame_bytes_sent = 0;
        while (frame_bytes_sent < RANDOM_BYTES || beats_checked < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                b = BYTE_W'($urandom);
                if (b == frame_start && r < 6)
                    b = b ^ 8'h01;
                send_byte(b);
            end
            else if (r < 16)
                send_frame(BYTE_W'($urandom_range(BUFFER_SIZE, 255)), -1, 1'b0);
            else if (r < 28)
                send_frame(BYTE_W'($urandom_range(0, 12)), -1, 1'b1);
            else if (r < 86)
                send_frame(BYTE_W'($urandom_range(0, 7)), -1, 1'b0);
            else
                send_frame(BYTE_W'($urandom_range(8, BUFFER_SIZE - 1)), -1, 1'b0);
        end
        drain_results();
    endtask

    task automatic test_no_idle();
        steady = 1'b1;
        repeat (2) send_frame(BYTE_W'($urandom_range(0, 9)), -1, 1'b0);
        send_frame(8'd4, -1, 1'b1);
        send_frame(8'd3, -1, 1'b0);
        drain_results();
        steady = 1'b0;
    endtask

    // receiver holds off while frames keep coming, so input must stall
    task automatic test_output_hold();
        hold_req = 1'b1;
        repeat (2) send_frame(BYTE_W'($urandom_range(2, 6)), -1, 1'b0);
        drain_results();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_start_byte_config();
        test_random_frames();
        test_no_idle();
        test_output_hold();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lcfp_pkg.sv
rtl/core/lcfp_ram.sv
rtl/core/lcfp_ctrl.sv
rtl/core/lcfp_datapath.sv
rtl/core/length_checksum_frame_parser_top.sv
tb/sv/tb_length_checksum_frame_parser_top.sv
